[rtl/mfm_ntd_pkg.sv]
package mfm_ntd_pkg;

	// Fixed field widths of the request and result items.
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned JIT_W     = 7;
	localparam int unsigned PM_W      = 10;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned PERIOD_W  = 32;

	// Divisor of the shared divider: a zero run plus one, or a sector count.
	localparam int unsigned DIV_W     = CNT_W + 1;

	// Numerator of the per-mille figure: a bad sector count times one thousand.
	localparam int unsigned PM_NUM_W  = CNT_W + PM_W;

	// Register reset values.
	localparam logic [CFG_W-1:0] START_CLOCK_RST   = 16'd2000;
	localparam logic [JIT_W-1:0] JITTER_RST        = 7'd20;
	localparam logic [CFG_W-1:0] WINDOW_BITS_RST   = 16'd1000;
	localparam logic [CFG_W-1:0] BAD_THRESHOLD_RST = 16'd20;

	// Arithmetic constants.
	localparam logic [CNT_W-1:0]    SAT16          = 16'hFFFF;
	localparam logic [PERIOD_W-1:0] SAT32          = 32'hFFFF_FFFF;
	localparam logic [PM_W-1:0]     PM_SCALE       = 10'd1000;
	localparam logic [PM_W-1:0]     PM_LIMIT       = 10'd909;
	localparam logic [JIT_W-1:0]    JIT_SCALE      = 7'd100;
	localparam logic [CNT_W-1:0]    ZERO_RUN_LIMIT = 16'd3;

	// Request commands.
	localparam logic CMD_BIT = 1'b0;
	localparam logic CMD_END = 1'b1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_START_CLOCK = 2'd0,
		CFG_JITTER      = 2'd1,
		CFG_WINDOW      = 2'd2,
		CFG_THRESHOLD   = 2'd3
	} cfg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_ZERO,
		S_DIV,
		S_DELTA,
		S_JMUL,
		S_JCMP,
		S_WIN,
		S_PMDIV,
		S_OUT
	} ntd_state_t;

	typedef struct packed {
		logic                cmd;
		logic                bit_value;
		logic [STAMP_W-1:0]  time_stamp;
	} in_item_t;

	typedef struct packed {
		logic               unformatted;
		logic [CNT_W-1:0]   bad_sector_count;
		logic [CNT_W-1:0]   sector_count;
		logic [PM_W-1:0]    bad_per_mille;
	} out_item_t;

	// Increment that sticks at the top of a 16-bit counter.
	function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
		return (v == SAT16) ? v : v + 16'd1;
	endfunction

endpackage

[rtl/mfm_ntd_div.sv]
module mfm_ntd_div #(
	parameter int unsigned DW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DW-1:0]                 dividend,
	input  logic [mfm_ntd_pkg::DIV_W-1:0] divisor,
	output logic                          done,
	output logic [DW-1:0]                 quotient
);
	import mfm_ntd_pkg::*;

	localparam int unsigned CW = $clog2(DW + 1);

	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [DW-1:0]    quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   trial;
	logic             borrow;
	logic [DIV_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit and try the subtraction.
	// The remainder stays below the divisor, so its top bit is always clear.
	assign trial    = {rem_q, quo_q[DW-1]} - {1'b0, dsr_q};
	assign borrow   = trial[DIV_W];
	assign rem_next = borrow ? {rem_q[DIV_W-2:0], quo_q[DW-1]} : trial[DIV_W-1:0];

	// Step counter; done pulses once, the cycle after the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register shifts out at the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DW-2:0], ~borrow};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/mfm_noise_track_detector.sv]
// Channel   Direction  Handshake                Payload
// in        request    in_valid / in_stall      in_data   (cmd, bit_value, time_stamp)
// out       result     out_valid / out_stall    out_data  (verdict and sector counts)
// cfg       write      cfg_we                   cfg_index, cfg_data
//
// A zero bit passes S_ZERO and S_WIN; a one bit waits in S_DIV for the bit-serial
// divider, DW bits wide, DW being the larger of TIME_WIDTH and 26, then passes
// S_DELTA, S_JMUL, S_JCMP and S_WIN. An end-of-track request passes S_PMDIV when
// sectors were seen, then S_OUT, where it waits for any previous verdict still held.
// Reset restores the register defaults and clears the track state; no sweep follows.
// A stalled verdict waits in the output register while the next bits are accepted.
module mfm_noise_track_detector #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mfm_ntd_pkg::in_item_t             in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mfm_ntd_pkg::out_item_t            out_data,
	input  logic                              cfg_we,
	input  mfm_ntd_pkg::cfg_idx_t             cfg_index,
	input  logic [mfm_ntd_pkg::CFG_W-1:0]     cfg_data
);
	import mfm_ntd_pkg::*;

	localparam int unsigned DIV_DW = (TIME_WIDTH > PM_NUM_W) ? TIME_WIDTH : PM_NUM_W;
	localparam int unsigned PROD_W = PERIOD_W + JIT_W + 1;

	ntd_state_t state_q, state_d;

	// Configuration registers.
	logic [CFG_W-1:0] start_clock_q;
	logic [JIT_W-1:0] jitter_q;
	logic [CFG_W-1:0] window_bits_q;
	logic [CFG_W-1:0] bad_thr_q;

	// Track state.
	logic [TIME_WIDTH-1:0] last_one_q;
	logic [PERIOD_W-1:0]   clk_est_q;
	logic [CNT_W-1:0]      zero_run_q;
	logic [CNT_W-1:0]      bad_bits_q;
	logic [CNT_W-1:0]      win_cnt_q;
	logic [CNT_W-1:0]      bad_sec_q;
	logic [CNT_W-1:0]      tot_sec_q;

	// Working registers of the current request.
	logic [TIME_WIDTH-1:0] stamp_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [PERIOD_W-1:0]   delta_q;
	logic [PROD_W-1:0]     lim_q;
	logic [PROD_W-1:0]     dev_q;
	logic [PM_W-1:0]       pm_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic                  accept;
	logic                  out_free;
	logic [TIME_WIDTH+STAMP_W-1:0] stamp_ext;
	logic [TIME_WIDTH-1:0] stamp_in;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [PM_NUM_W-1:0]   pm_num;
	logic                  div_start;
	logic [DIV_DW-1:0]     div_dividend;
	logic [DIV_W-1:0]      div_divisor;
	logic                  div_done;
	logic [DIV_DW-1:0]     div_quo;
	logic [DIV_DW+PERIOD_W-1:0] quo_ext;
	logic [PERIOD_W-1:0]   period_sat;
	logic [JIT_W:0]        jit_plus;
	logic [PROD_W-1:0]     lim_d;
	logic [PROD_W-1:0]     dev_d;
	logic [CNT_W-1:0]      zr_inc;
	logic [CNT_W-1:0]      win_inc;
	logic                  verdict_unf;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Time stamps are taken modulo 2^TIME_WIDTH.
	assign stamp_ext = {{TIME_WIDTH{1'b0}}, in_data.time_stamp};
	assign stamp_in  = stamp_ext[TIME_WIDTH-1:0];
	assign elapsed   = stamp_in - last_one_q;
	assign pm_num    = bad_sec_q * PM_SCALE;

	// The divider serves both the bit-cell period and the per-mille figure.
	assign div_start = (state_q == S_IDLE) && accept &&
		((in_data.cmd == CMD_END) ? (tot_sec_q != '0) : in_data.bit_value);

	always_comb begin
		if (in_data.cmd == CMD_END) begin
			div_dividend = DIV_DW'(pm_num);
			div_divisor  = {1'b0, tot_sec_q};
		end else begin
			div_dividend = DIV_DW'(elapsed);
			div_divisor  = {1'b0, zero_run_q} + 17'd1;
		end
	end

	mfm_ntd_div #(
		.DW (DIV_DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// A period beyond 32 bits saturates.
	assign quo_ext    = {{PERIOD_W{1'b0}}, div_quo};
	assign period_sat = (quo_ext[DIV_DW+PERIOD_W-1:PERIOD_W] != '0) ? SAT32
		: quo_ext[PERIOD_W-1:0];

	// Jitter test without division: dev*100/est > j holds exactly when
	// dev*100 >= (j+1)*est.
	assign jit_plus = {1'b0, jitter_q} + 8'd1;
	assign lim_d    = jit_plus * clk_est_q;
	assign dev_d    = delta_q * JIT_SCALE;

	assign zr_inc      = sat_inc16(zero_run_q);
	assign win_inc     = sat_inc16(win_cnt_q);
	assign verdict_unf = !((bad_sec_q < tot_sec_q) && (pm_q <= PM_LIMIT));

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state; requests are taken only between items.
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.cmd == CMD_END) begin
						state_d = (tot_sec_q != '0) ? S_PMDIV : S_OUT;
					end else if (in_data.bit_value) begin
						state_d = S_DIV;
					end else begin
						state_d = S_ZERO;
					end
				end
			end
			S_ZERO:  state_d = S_WIN;
			S_DIV: begin
				if (div_done) begin
					state_d = S_DELTA;
				end
			end
			S_DELTA: state_d = S_JMUL;
			S_JMUL:  state_d = S_JCMP;
			S_JCMP:  state_d = S_WIN;
			S_WIN:   state_d = S_IDLE;
			S_PMDIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_clock_q <= START_CLOCK_RST;
			jitter_q      <= JITTER_RST;
			window_bits_q <= WINDOW_BITS_RST;
			bad_thr_q     <= BAD_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_CLOCK: start_clock_q <= cfg_data;
				CFG_JITTER:      jitter_q      <= cfg_data[JIT_W-1:0];
				CFG_WINDOW:      window_bits_q <= cfg_data;
				CFG_THRESHOLD:   bad_thr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Track state: bit accounting, window closing and the clear after a verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_one_q <= '0;
			clk_est_q  <= PERIOD_W'(START_CLOCK_RST);
			zero_run_q <= '0;
			bad_bits_q <= '0;
			win_cnt_q  <= '0;
			bad_sec_q  <= '0;
			tot_sec_q  <= '0;
		end else begin
			case (state_q)
				S_ZERO: begin
					zero_run_q <= zr_inc;
					if (zr_inc > ZERO_RUN_LIMIT) begin
						bad_bits_q <= sat_inc16(bad_bits_q);
					end
				end
				S_JCMP: begin
					if (clk_est_q == '0 || dev_q >= lim_q) begin
						bad_bits_q <= sat_inc16(bad_bits_q);
					end
					clk_est_q  <= period_q;
					last_one_q <= stamp_q;
					zero_run_q <= '0;
				end
				S_WIN: begin
					if (win_inc >= window_bits_q) begin
						if (bad_bits_q >= bad_thr_q) begin
							bad_sec_q <= sat_inc16(bad_sec_q);
						end
						tot_sec_q  <= sat_inc16(tot_sec_q);
						bad_bits_q <= '0;
						win_cnt_q  <= '0;
					end else begin
						win_cnt_q <= win_inc;
					end
				end
				S_OUT: begin
					if (out_free) begin
						last_one_q <= '0;
						clk_est_q  <= PERIOD_W'(start_clock_q);
						zero_run_q <= '0;
						bad_bits_q <= '0;
						win_cnt_q  <= '0;
						bad_sec_q  <= '0;
						tot_sec_q  <= '0;
					end
				end
				default: ;
			endcase
			// A new start clock also becomes the current estimate.
			if (cfg_we && cfg_index == CFG_START_CLOCK) begin
				clk_est_q <= PERIOD_W'(cfg_data);
			end
		end
	end

	// Working registers of the request in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					stamp_q <= stamp_in;
					pm_q    <= '0;
				end
			end
			S_DIV: begin
				if (div_done) begin
					period_q <= period_sat;
				end
			end
			S_DELTA: begin
				delta_q <= (period_q >= clk_est_q) ? period_q - clk_est_q
					: clk_est_q - period_q;
				lim_q   <= lim_d;
			end
			S_JMUL: dev_q <= dev_d;
			S_PMDIV: begin
				if (div_done) begin
					pm_q <= div_quo[PM_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Output register holds the verdict until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_q.unformatted      <= verdict_unf;
			out_q.bad_sector_count <= bad_sec_q;
			out_q.sector_count     <= tot_sec_q;
			out_q.bad_per_mille    <= pm_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/mfm_ntd_chk.sv]
module mfm_ntd_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input mfm_ntd_pkg::out_item_t out_data
);
	import mfm_ntd_pkg::*;

	// A stalled verdict stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("verdict changed while stalled");

	// Every accepted request makes the block busy, so in_stall is raised after it.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted on consecutive cycles");

	// A formatted verdict needs fewer bad sectors than sectors and a figure within PM_LIMIT.
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.unformatted ||
			(out_data.bad_sector_count < out_data.sector_count &&
			 out_data.bad_per_mille <= PM_LIMIT))
		else $error("formatted verdict with inconsistent counts");

	// With no sectors the figure is zero and the track is unformatted.
	a_no_sectors: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sector_count == '0 |->
			out_data.bad_per_mille == '0 && out_data.unformatted)
		else $error("empty track verdict wrong");

	// A fresh verdict follows a busy cycle of the sequencer.
	a_verdict_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("verdict appeared without work");

endmodule

bind mfm_noise_track_detector mfm_ntd_chk u_ntd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

[verif/mfm_noise_track_detector_tb.sv]
`timescale 1ns / 100ps

module mfm_noise_track_detector_tb;
	import mfm_ntd_pkg::*;

	// Settling wait that covers any request still in flight.
	localparam int SETTLE_CYCLES  = 64;
	localparam int ROUNDS         = 8;
	localparam int ROUND_REQUESTS = 140;
	localparam int REPORT_LIMIT   = 10;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	in_item_t          in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_data;
	logic              cfg_we    = 1'b0;
	cfg_idx_t          cfg_index = CFG_START_CLOCK;
	logic [CFG_W-1:0]  cfg_data  = '0;

	// Register copies, as after reset.
	logic [CFG_W-1:0]  start_clk   = START_CLOCK_RST;
	logic [JIT_W-1:0]  jitter_pct  = JITTER_RST;
	logic [CFG_W-1:0]  window_len  = WINDOW_BITS_RST;
	logic [CFG_W-1:0]  bad_thresh  = BAD_THRESHOLD_RST;

	// Track state of the verdict predictor.
	logic [STAMP_W-1:0]  last_one     = '0;
	logic [PERIOD_W-1:0] clock_est    = PERIOD_W'(START_CLOCK_RST);
	logic [CNT_W-1:0]    zero_run     = '0;
	logic [CNT_W-1:0]    bad_bits     = '0;
	logic [CNT_W-1:0]    window_fill  = '0;
	logic [CNT_W-1:0]    bad_windows  = '0;
	logic [CNT_W-1:0]    sectors_seen = '0;

	in_item_t  pending_reqs[$];
	out_item_t verdicts[$];

	int          fail_count = 0;
	int          queued     = 0;
	int          gap_left   = 0;
	int          stall_left = 0;
	bit          calm       = 1'b0;
	bit          req_taken  = 1'b0;
	logic [31:0] gen_last;
	logic [31:0] gen_period;

	mfm_noise_track_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == SAT16) ? v : v + 1'b1;
	endfunction

	// Follows one accepted request through the track state and records any verdict.
	task automatic follow_request(input in_item_t r);
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] delta;
		logic [63:0]         scaled;
		out_item_t           v;
		if (r.cmd == CMD_END) begin
			v.bad_sector_count = bad_windows;
			v.sector_count     = sectors_seen;
			v.bad_per_mille    = (sectors_seen == 0) ? '0 :
				PM_W'((32'(bad_windows) * 32'(PM_SCALE)) / 32'(sectors_seen));
			v.unformatted = !(bad_windows < sectors_seen && v.bad_per_mille <= PM_LIMIT);
			verdicts.push_back(v);
			last_one     = '0;
			clock_est    = PERIOD_W'(start_clk);
			zero_run     = '0;
			bad_bits     = '0;
			window_fill  = '0;
			bad_windows  = '0;
			sectors_seen = '0;
		end else begin
			if (r.bit_value) begin
				// New cell period from the time since the last one bit.
				period = (r.time_stamp - last_one) / (PERIOD_W'(zero_run) + 1);
				delta  = (period >= clock_est) ? period - clock_est : clock_est - period;
				scaled = 64'(delta) * 64'(JIT_SCALE);
				if (clock_est == 0 || scaled / 64'(clock_est) > 64'(jitter_pct))
					bad_bits = count_up(bad_bits);
				clock_est = period;
				last_one  = r.time_stamp;
				zero_run  = '0;
			end else begin
				zero_run = count_up(zero_run);
				if (zero_run > ZERO_RUN_LIMIT)
					bad_bits = count_up(bad_bits);
			end
			// Close the sector window once it is full.
			window_fill = count_up(window_fill);
			if (window_fill >= window_len) begin
				if (bad_bits >= bad_thresh)
					bad_windows = count_up(bad_windows);
				sectors_seen = count_up(sectors_seen);
				bad_bits     = '0;
				window_fill  = '0;
			end
		end
	endtask

	task automatic report_fault(input string what, input out_item_t want, input out_item_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t %s: expected unf=%0d bad=%0d sectors=%0d pm=%0d,",
				$time, what, want.unformatted, want.bad_sector_count, want.sector_count,
				want.bad_per_mille, " got unf=%0d bad=%0d sectors=%0d pm=%0d",
				got.unformatted, got.bad_sector_count, got.sector_count,
				got.bad_per_mille);
	endtask

	task automatic check_verdict(input out_item_t got);
		out_item_t want;
		if (verdicts.size() == 0) begin
			report_fault("verdict with none pending", '0, got);
		end else begin
			want = verdicts.pop_front();
			if (got.unformatted !== want.unformatted ||
			    got.bad_sector_count !== want.bad_sector_count ||
			    got.sector_count !== want.sector_count ||
			    got.bad_per_mille !== want.bad_per_mille)
				report_fault("verdict mismatch", want, got);
		end
	endtask

	// Monitor: requests and verdicts are taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				follow_request(in_data);
				req_taken = 1'b1;
			end
			if (out_valid && !out_stall)
				check_verdict(out_data);
		end
	end

	// Driver: a request is held until taken, then a random gap may follow.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !req_taken) begin
				// Still waiting for the block to take the request.
			end else begin
				req_taken = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					in_data  <= pending_reqs.pop_front();
					in_valid <= 1'b1;
					gap_left = calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (calm) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0)
				stall_left = pick_gap();
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		case (idx)
			CFG_START_CLOCK: begin
				start_clk = CFG_W'(val);
				clock_est = PERIOD_W'(start_clk);
			end
			CFG_JITTER:    jitter_pct = JIT_W'(val);
			CFG_WINDOW:    window_len = CFG_W'(val);
			CFG_THRESHOLD: bad_thresh = CFG_W'(val);
			default: ;
		endcase
	endtask

	task automatic set_config(input int sc, input int jit, input int win, input int thr);
		write_reg(CFG_START_CLOCK, sc);
		write_reg(CFG_JITTER, jit);
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_THRESHOLD, thr);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_bit(input logic b, input logic [STAMP_W-1:0] stamp);
		in_item_t r;
		r.cmd        = CMD_BIT;
		r.bit_value  = b;
		r.time_stamp = stamp;
		pending_reqs.push_back(r);
		queued++;
	endtask

	// The bit and stamp of an end-of-track request are ignored, so they are random.
	task automatic queue_end();
		in_item_t r;
		r.cmd        = CMD_END;
		r.bit_value  = 1'($urandom());
		r.time_stamp = $urandom();
		pending_reqs.push_back(r);
		queued++;
	endtask

	// One track: mostly clean flux with short zero runs and mild jitter, otherwise
	// random noise, or a broken stretch that may run into the next track.
	task automatic queue_track();
		int          shape;
		int          n;
		int          z;
		int          pct;
		logic [31:0] wobble;
		shape      = $urandom_range(0, 9);
		n          = $urandom_range(3, 30);
		gen_period = 32'(start_clk);
		gen_last   = ($urandom_range(0, 7) == 0) ?
			32'hFFFF_FFFF - 32'($urandom_range(0, 1000)) : 32'd0;
		for (int i = 0; i < n; i++) begin
			if (shape <= 6) begin
				z = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
				repeat (z) queue_bit(1'b0, $urandom());
				pct      = ($urandom_range(0, 4) == 0) ? 45 : 12;
				wobble   = 32'((longint'(gen_period) * $urandom_range(0, pct)) / 100);
				gen_last = gen_last + gen_period * 32'(z + 1);
				gen_last = $urandom_range(0, 1) ? gen_last + wobble : gen_last - wobble;
				queue_bit(1'b1, gen_last);
				// Slow drift of the spindle speed.
				if ($urandom_range(0, 15) == 0)
					gen_period = $urandom_range(0, 1) ? gen_period + gen_period / 8 :
						gen_period - gen_period / 8;
			end else if (shape <= 8) begin
				queue_bit(1'($urandom()), $urandom());
			end else begin
				repeat ($urandom_range(0, 12)) queue_bit(1'b0, $urandom());
				queue_bit(1'b1, $urandom());
			end
		end
		if (shape != 9 || $urandom_range(0, 1))
			queue_end();
	endtask

	// Waits until every request is taken and every verdict is back, then settles.
	task automatic drain();
		@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int target;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// An empty track straight after reset.
		queue_end();
		drain();

		// Clean cells, a long zero run, a jump, the stamp wrap and a zero estimate.
		set_config(100, 20, 4, 1);
		queue_bit(1'b1, 32'd100);
		queue_bit(1'b1, 32'd200);
		repeat (5) queue_bit(1'b0, $urandom());
		queue_bit(1'b1, 32'd800);
		queue_bit(1'b1, 32'd930);
		queue_bit(1'b1, 32'hFFFF_FFFF);
		queue_bit(1'b1, 32'h0000_0000);
		queue_bit(1'b1, 32'h0000_0000);
		queue_bit(1'b1, 32'd5);
		queue_end();
		drain();

		// Zero start clock, every bit a window and every window bad.
		set_config(0, 100, 0, 0);
		queue_bit(1'b1, 32'd7);
		queue_bit(1'b0, $urandom());
		queue_end();
		drain();

		// Random rounds, each under its own register setting, with a pause between them.
		for (int round = 0; round < ROUNDS; round++) begin
			case (round)
				0: set_config(1, 0, 1, 1);
				1: set_config(65535, 100, 65535, 65535);
				default: set_config($urandom_range(20, 3000), $urandom_range(0, 100),
					$urandom_range(1, 12), $urandom_range(1, 6));
			endcase
			calm   = (round % 3 == 2);
			target = queued + ROUND_REQUESTS;
			while (queued < target)
				queue_track();
			drain();
		end

		if (fail_count == 0 && verdicts.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
